/* sv/sekf_pkg.sv */
// ============================================================================
// sekf_pkg
// Shared types and constants for the stack engine with key filter.
// ============================================================================
package sekf_pkg;

    // One stack entry: leg count and opaque tag word
    typedef struct packed {
        logic [7:0]  legs;
        logic [31:0] tag;
    } t_entry;

    // Operation codes; six and seven are unused and report ok
    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_DUP    = 3'd3,
        OP_SWAP   = 3'd4,
        OP_FILTER = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    // Leg count that the filter removes
    localparam logic [7:0] LEGS_DROP = 8'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WB,
        S_SWAP_LO,
        S_SWAP_HI,
        S_FILT,
        S_FILT_END,
        S_RESULT
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_PUSH,
        CMD_POP,
        CMD_POP_WB,
        CMD_DUP,
        CMD_SWAP_RD,
        CMD_SWAP_LO,
        CMD_SWAP_HI,
        CMD_FILT_START,
        CMD_FILT_STEP,
        CMD_FILT_END,
        CMD_LOAD_OUT
    } t_cmd;

    // Controller to datapath
    typedef struct packed {
        t_cmd    cmd;
        t_status status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic lt2;
        logic full;
        logic filt_last;
        logic out_free;
    } t_dp_stat;

endpackage

/* sv/sekf_ctrl.sv */
// ============================================================================
// sekf_ctrl
// Operation sequencer: decodes each operation, checks it against the stack
// status and steps the datapath through it.
// ============================================================================
module sekf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_op,
    input  sekf_pkg::t_dp_stat  i_stat,
    output sekf_pkg::t_dp_cmd   o_cmd
);
    import sekf_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    t_cmd    cmd;
    logic    accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_POP:        n_state = S_POP_WB;
                        CMD_SWAP_RD:    n_state = S_SWAP_LO;
                        CMD_FILT_START: n_state = S_FILT;
                        default:        n_state = S_RESULT;
                    endcase
                end
            end
            S_POP_WB:   n_state = S_RESULT;
            S_SWAP_LO:  n_state = S_SWAP_HI;
            S_SWAP_HI:  n_state = S_RESULT;
            S_FILT: begin
                if (i_stat.filt_last) begin
                    n_state = S_FILT_END;
                end
            end
            S_FILT_END: n_state = S_RESULT;
            S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = CMD_NONE;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    case (t_op'(i_op))
                        OP_PUSH: begin
                            if (i_stat.full) n_status = ST_OVER;
                            else             cmd = CMD_PUSH;
                        end
                        OP_POP: begin
                            if (i_stat.empty) n_status = ST_UNDER;
                            else              cmd = CMD_POP;
                        end
                        OP_PEEK: begin
                            if (i_stat.empty) n_status = ST_UNDER;
                        end
                        OP_DUP: begin
                            if (i_stat.empty)     n_status = ST_UNDER;
                            else if (i_stat.full) n_status = ST_OVER;
                            else                  cmd = CMD_DUP;
                        end
                        OP_SWAP: begin
                            if (i_stat.lt2) n_status = ST_UNDER;
                            else            cmd = CMD_SWAP_RD;
                        end
                        OP_FILTER: begin
                            if (i_stat.empty) n_status = ST_UNDER;
                            else              cmd = CMD_FILT_START;
                        end
                        default: ;
                    endcase
                end
            end
            S_POP_WB:   cmd = CMD_POP_WB;
            S_SWAP_LO:  cmd = CMD_SWAP_LO;
            S_SWAP_HI:  cmd = CMD_SWAP_HI;
            S_FILT:     cmd = CMD_FILT_STEP;
            S_FILT_END: cmd = CMD_FILT_END;
            S_RESULT: begin
                if (i_stat.out_free) cmd = CMD_LOAD_OUT;
            end
            default:    cmd = CMD_NONE;
        endcase
    end

    assign o_cmd.cmd    = cmd;
    assign o_cmd.status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

/* sv/sekf_datapath.sv */
// ============================================================================
// sekf_datapath
// Entry memory, fill count, cached top entry, filter pointers, capacity
// register and the result register.
// ============================================================================
module sekf_datapath #(
    parameter int MAX_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sekf_pkg::t_dp_cmd   i_cmd,
    output sekf_pkg::t_dp_stat  o_stat,
    input  logic [7:0]          i_item_legs,
    input  logic [31:0]         i_item_tag,
    input  logic                i_cfg_valid,
    input  logic [6:0]          i_cfg_capacity,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_top_legs,
    output logic [31:0]         o_top_tag,
    output logic [6:0]          o_depth,
    output logic                o_is_empty,
    output logic                o_is_full,
    output logic [1:0]          o_status
);
    import sekf_pkg::*;

    localparam int AW   = $clog2(MAX_DEPTH);
    localparam int CW   = $clog2(MAX_DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    t_entry mem [MAX_DEPTH];

    logic [CW-1:0] r_count, n_count;
    t_entry        r_top, n_top;
    t_entry        r_rd_data;
    logic [AW-1:0] r_rp, n_rp;
    logic [AW-1:0] r_wp, n_wp;
    logic          r_fvalid, n_fvalid;
    logic [6:0]    r_cap;

    logic          r_out_valid;
    t_entry        r_out_top;
    logic [6:0]    r_out_depth;
    logic          r_out_empty;
    logic          r_out_full;
    t_status       r_out_status;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic [AW-1:0] rd_addr;

    logic [CMPW-1:0] ucap;
    logic            empty;
    logic            full;
    logic            keep;
    logic [AW-1:0]   addr_top;
    logic [AW-1:0]   addr_second;
    logic [AW-1:0]   addr_next;

    assign ucap = (CMPW'(r_cap) > CMPW'(MAX_DEPTH)) ? CMPW'(MAX_DEPTH) : CMPW'(r_cap);
    assign empty = (r_count == '0);
    assign full  = (CMPW'(r_count) >= ucap);

    assign addr_top    = AW'(r_count - CW'(1));
    assign addr_second = AW'(r_count - CW'(2));
    assign addr_next   = AW'(r_count);

    assign keep = r_fvalid && (r_rd_data.legs != LEGS_DROP);

    assign o_stat.empty     = empty;
    assign o_stat.lt2       = (r_count < CW'(2));
    assign o_stat.full      = full;
    assign o_stat.filt_last = (r_rp == addr_top);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_count  = r_count;
        n_top    = r_top;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_fvalid = r_fvalid;
        wr_en    = 1'b0;
        wr_addr  = addr_next;
        wr_data  = r_top;
        rd_addr  = addr_second;
        case (i_cmd.cmd)
            CMD_PUSH: begin
                wr_en        = 1'b1;
                wr_data.legs = i_item_legs;
                wr_data.tag  = i_item_tag;
                n_top        = wr_data;
                n_count      = r_count + CW'(1);
            end
            CMD_POP: begin
                n_count = r_count - CW'(1);
            end
            CMD_POP_WB: begin
                n_top = r_rd_data;
            end
            CMD_DUP: begin
                wr_en   = 1'b1;
                n_count = r_count + CW'(1);
            end
            CMD_SWAP_LO: begin
                // old top goes one below, old second becomes top
                wr_en   = 1'b1;
                wr_addr = addr_second;
                n_top   = r_rd_data;
            end
            CMD_SWAP_HI: begin
                wr_en   = 1'b1;
                wr_addr = addr_top;
            end
            CMD_FILT_START: begin
                n_rp     = '0;
                n_wp     = '0;
                n_fvalid = 1'b0;
            end
            CMD_FILT_STEP: begin
                rd_addr  = r_rp;
                n_rp     = r_rp + AW'(1);
                n_fvalid = 1'b1;
                wr_en    = keep;
                wr_addr  = r_wp;
                wr_data  = r_rd_data;
                if (keep) begin
                    n_top = r_rd_data;
                    n_wp  = r_wp + AW'(1);
                end
            end
            CMD_FILT_END: begin
                wr_en    = keep;
                wr_addr  = r_wp;
                wr_data  = r_rd_data;
                n_fvalid = 1'b0;
                n_count  = CW'(r_wp) + CW'(keep);
                if (keep) begin
                    n_top = r_rd_data;
                end
            end
            default: ;
        endcase
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_rp  <= n_rp;
        r_wp  <= n_wp;
        if (i_cmd.cmd == CMD_LOAD_OUT) begin
            r_out_top    <= empty ? '0 : r_top;
            r_out_depth  <= 7'(r_count);
            r_out_empty  <= empty;
            r_out_full   <= full;
            r_out_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_fvalid    <= 1'b0;
            r_cap       <= 7'd64;
            r_out_valid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_fvalid <= n_fvalid;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_capacity;
            end
            if (i_cmd.cmd == CMD_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_top_legs  = r_out_top.legs;
    assign o_top_tag   = r_out_top.tag;
    assign o_depth     = r_out_depth;
    assign o_is_empty  = r_out_empty;
    assign o_is_full   = r_out_full;
    assign o_status    = r_out_status;

endmodule

/* sv/stack_engine_with_key_filter.sv */
// ============================================================================
// stack_engine_with_key_filter
// Bounded LIFO stack of (leg count, tag) entries with push, pop, peek,
// duplicate, swap and a filter that drops every two-leg entry.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per
//   transfer: i_op, plus i_item_legs / i_item_tag for push. Each operation
//   yields exactly one result transfer on the output channel (o_out_valid /
//   i_out_ready): top entry (zero when empty), depth, empty/full flags and a
//   status of ok, underflow or overflow. A rejected operation leaves the
//   stack unchanged.
//   One operation is worked at a time. Push, peek, duplicate, unused codes
//   and any error go straight to the result; pop adds a top writeback, swap
//   a read and a low and a high write, and the filter walks every held entry
//   through the single read port and single write port of the entry memory.
//   The next operation is taken the cycle after the result is loaded.
//   The capacity register is written through i_cfg_valid / o_cfg_ready
//   (always ready); write it only while no operation is in flight, which
//   the block does not enforce. Values above MAX_DEPTH act as MAX_DEPTH.
//   Reset empties the stack, sets capacity to 64 and drops any pending
//   result; the entry memory is not cleared and needs no clearing pass.
//   While the receiver stalls, the result register holds its transfer and
//   no further operation is accepted after the one that follows it.
// ============================================================================
module stack_engine_with_key_filter #(
    parameter int MAX_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_item_legs,
    input  logic [31:0] i_item_tag,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_capacity,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_top_legs,
    output logic [31:0] o_top_tag,
    output logic [6:0]  o_depth,
    output logic        o_is_empty,
    output logic        o_is_full,
    output logic [1:0]  o_status
);
    import sekf_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Capacity writes are taken at once; never stall them
    assign o_cfg_ready = 1'b1;

    // Sequencer: decode, check against stack status, step the datapath
    sekf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Entry memory, count, cached top, filter pointers, result register
    sekf_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_item_legs    (i_item_legs),
        .i_item_tag     (i_item_tag),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_top_legs     (o_top_legs),
        .o_top_tag      (o_top_tag),
        .o_depth        (o_depth),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .o_status       (o_status)
    );

endmodule

/* tb/tb_stack_engine_with_key_filter.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_stack_engine_with_key_filter
// Self-checking bench for the leg/tag LIFO stack. A directed table covers
// empty-stack errors, unused codes, field extremes, full and lowered
// capacity, and the two-leg filter. Random phases at several capacities
// follow. Every result transfer is checked field by field against a local
// stack model, under random idling on both channels and one long output
// stall.
// ============================================================================
module tb_stack_engine_with_key_filter;
    import sekf_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 11;
    localparam int STACK_SLOTS = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;

    // Op codes the block treats as no-ops
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // One result transfer as seen on the output ports
    typedef struct packed {
        logic [7:0]  top_legs;
        logic [31:0] top_tag;
        logic [6:0]  depth;
        logic        is_empty;
        logic        is_full;
        logic [1:0]  status;
    } t_report;

    localparam t_report EMPTY_UNDER = '{8'd0, 32'd0, 7'd0, 1'b1, 1'b0, ST_UNDER};
    localparam t_report EMPTY_OK    = '{8'd0, 32'd0, 7'd0, 1'b1, 1'b0, ST_OK};

    typedef enum logic {
        ROW_OP,
        ROW_CFG
    } t_row_kind;

    // Directed row: an operation (typed result optional) or a capacity write
    typedef struct {
        t_row_kind   kind;
        logic [2:0]  op;
        logic [7:0]  legs;
        logic [31:0] tag;
        logic [6:0]  cap;
        bit          typed;
        t_report     rep;
    } t_row;

    // Random phase: capacity, item count, push share, idling, long stall
    typedef struct {
        logic [6:0] cap;
        int         n_ops;
        int         push_pct;
        bit         idle;
        bit         hold;
    } t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_op;
    logic [7:0]  i_item_legs;
    logic [31:0] i_item_tag;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_capacity;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_top_legs;
    logic [31:0] o_top_tag;
    logic [6:0]  o_depth;
    logic        o_is_empty;
    logic        o_is_full;
    logic [1:0]  o_status;

    // Local stack model
    t_entry      stk_mem [STACK_SLOTS];
    int unsigned stk_fill;
    int unsigned stk_cap;

    t_report     report_q [$];
    t_row        dir_tab [$];
    t_phase      phases [7];

    int          err_cnt = 0;
    int          cyc_cnt = 0;
    bit          idle_on;
    bit          hold_req;

    stack_engine_with_key_filter #(
        .MAX_DEPTH(STACK_SLOTS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_item_legs    (i_item_legs),
        .i_item_tag     (i_item_tag),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_top_legs     (o_top_legs),
        .o_top_tag      (o_top_tag),
        .o_depth        (o_depth),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .o_status       (o_status)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Apply one operation to the local stack and return the report it yields.
    // Rejected operations leave the stack untouched.
    function automatic t_report stack_apply_op(input logic [2:0] op,
                                               input logic [7:0] legs,
                                               input logic [31:0] tag);
        t_report     rep;
        t_entry      tmp;
        t_status     st;
        int unsigned wr;
        int unsigned rd;
        st = ST_OK;
        case (op)
            OP_PUSH: begin
                if (stk_fill >= stk_cap) begin
                    st = ST_OVER;
                end else begin
                    stk_mem[stk_fill] = '{legs, tag};
                    stk_fill++;
                end
            end
            OP_POP: begin
                if (stk_fill == 0) st = ST_UNDER;
                else stk_fill--;
            end
            OP_PEEK: begin
                if (stk_fill == 0) st = ST_UNDER;
            end
            OP_DUP: begin
                // Empty wins over full, even at capacity zero
                if (stk_fill == 0) begin
                    st = ST_UNDER;
                end else if (stk_fill >= stk_cap) begin
                    st = ST_OVER;
                end else begin
                    stk_mem[stk_fill] = stk_mem[stk_fill - 1];
                    stk_fill++;
                end
            end
            OP_SWAP: begin
                if (stk_fill < 2) begin
                    st = ST_UNDER;
                end else begin
                    tmp = stk_mem[stk_fill - 1];
                    stk_mem[stk_fill - 1] = stk_mem[stk_fill - 2];
                    stk_mem[stk_fill - 2] = tmp;
                end
            end
            OP_FILTER: begin
                if (stk_fill == 0) begin
                    st = ST_UNDER;
                end else begin
                    // Compact survivors toward the bottom, keeping their order
                    wr = 0;
                    for (rd = 0; rd < stk_fill; rd++) begin
                        if (stk_mem[rd].legs != LEGS_DROP) begin
                            stk_mem[wr] = stk_mem[rd];
                            wr++;
                        end
                    end
                    stk_fill = wr;
                end
            end
            default: ;
        endcase
        if (stk_fill > 0) begin
            rep.top_legs = stk_mem[stk_fill - 1].legs;
            rep.top_tag  = stk_mem[stk_fill - 1].tag;
        end else begin
            rep.top_legs = '0;
            rep.top_tag  = '0;
        end
        rep.depth    = 7'(stk_fill);
        rep.is_empty = (stk_fill == 0);
        rep.is_full  = (stk_fill >= stk_cap);
        rep.status   = st;
        return rep;
    endfunction

    function automatic logic [2:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return OP_PUSH;
        r = $urandom_range(0, 99);
        if (r < 25) return OP_POP;
        if (r < 42) return OP_PEEK;
        if (r < 59) return OP_DUP;
        if (r < 76) return OP_SWAP;
        if (r < 92) return OP_FILTER;
        return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    endfunction

    // Bias leg counts toward the filtered value and the extremes
    function automatic logic [7:0] pick_legs();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return LEGS_DROP;
        if (r < 35) return 8'd0;
        if (r < 40) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void check_field(input string name,
                                        input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic add_op(input logic [2:0] op, input logic [7:0] legs,
                          input logic [31:0] tag);
        dir_tab.push_back(t_row'{ROW_OP, op, legs, tag, 7'd0, 1'b0, '0});
    endtask

    task automatic add_chk(input logic [2:0] op, input logic [7:0] legs,
                           input logic [31:0] tag, input t_report rep);
        dir_tab.push_back(t_row'{ROW_OP, op, legs, tag, 7'd0, 1'b1, rep});
    endtask

    task automatic add_cfg(input logic [6:0] cap);
        dir_tab.push_back(t_row'{ROW_CFG, OP_PUSH, 8'd0, 32'd0, cap, 1'b0, '0});
    endtask

    // Offer one operation; hold valid and payload until the transfer, then
    // queue its expected report. Valid is not lowered after the transfer, so a
    // following item can keep it high without a second assignment in the same step.
    task automatic send_op(input logic [2:0] op, input logic [7:0] legs,
                           input logic [31:0] tag, input bit typed,
                           input t_report typed_rep);
        t_report pred;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_item_legs <= legs;
        i_item_tag  <= tag;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = stack_apply_op(op, legs, tag);
        report_q.push_back(typed ? typed_rep : pred);
    endtask

    // Drop valid and wait until every queued report has come back
    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
    endtask

    // Write capacity only with nothing in flight
    task automatic write_capacity(input logic [6:0] cap);
        drain_reports();
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        stk_cap = (cap > STACK_SLOTS) ? STACK_SLOTS : cap;
    endtask

    // Result checker: compare each output transfer with the oldest report
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (report_q.size() == 0) begin
                $error("result transfer with no operation pending");
                err_cnt++;
            end else begin
                want = report_q.pop_front();
                check_field("top_legs", want.top_legs, o_top_legs);
                check_field("top_tag",  want.top_tag,  o_top_tag);
                check_field("depth",    want.depth,    o_depth);
                check_field("is_empty", want.is_empty, o_is_empty);
                check_field("is_full",  want.is_full,  o_is_full);
                check_field("status",   want.status,   o_status);
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // block backs up and stalls its input.
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : main_seq
        t_row       row;
        t_phase     ph;
        logic [2:0] rop;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = OP_PUSH;
        i_item_legs    = '0;
        i_item_tag     = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_capacity = '0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        stk_fill       = 0;
        stk_cap        = STACK_SLOTS;
        foreach (stk_mem[i]) stk_mem[i] = '0;

        // Directed table at a small capacity so full is reached quickly
        add_cfg(7'd4);
        // Every op on an empty stack; unused codes report ok
        add_chk(OP_POP,      8'd0, 32'd0, EMPTY_UNDER);
        add_chk(OP_PEEK,     8'd0, 32'd0, EMPTY_UNDER);
        add_chk(OP_DUP,      8'd0, 32'd0, EMPTY_UNDER);
        add_chk(OP_SWAP,     8'd0, 32'd0, EMPTY_UNDER);
        add_chk(OP_FILTER,   8'd0, 32'd0, EMPTY_UNDER);
        add_chk(OP_SPARE_LO, 8'd0, 32'd0, EMPTY_OK);
        add_chk(OP_SPARE_HI, 8'd0, 32'd0, EMPTY_OK);
        // Field extremes and swap with one and two entries
        add_chk(OP_PUSH, 8'd0, 32'd0, '{8'd0, 32'd0, 7'd1, 1'b0, 1'b0, ST_OK});
        add_chk(OP_SWAP, 8'd0, 32'd0, '{8'd0, 32'd0, 7'd1, 1'b0, 1'b0, ST_UNDER});
        add_chk(OP_PUSH, 8'd255, 32'hFFFF_FFFF,
                '{8'd255, 32'hFFFF_FFFF, 7'd2, 1'b0, 1'b0, ST_OK});
        add_chk(OP_SWAP, 8'd0, 32'd0, '{8'd0, 32'd0, 7'd2, 1'b0, 1'b0, ST_OK});
        // Fill up, overflow on push and duplicate, then filter
        add_op(OP_PUSH,   LEGS_DROP, 32'hA5A5_5A5A);
        add_op(OP_DUP,    8'd0, 32'd0);
        add_op(OP_PUSH,   8'd1, 32'h0000_0001);
        add_op(OP_DUP,    8'd0, 32'd0);
        add_op(OP_FILTER, 8'd0, 32'd0);
        add_op(OP_PEEK,   8'd0, 32'd0);
        // Lower capacity below the depth: entries stay, pushes overflow
        add_cfg(7'd1);
        add_op(OP_PUSH, 8'd7, 32'h1234_5678);
        add_op(OP_POP,  8'd0, 32'd0);
        add_op(OP_POP,  8'd0, 32'd0);
        // Zero capacity: reports full while empty, duplicate still underflows
        add_cfg(7'd0);
        add_op(OP_PUSH, 8'd9, 32'h5A5A_A5A5);
        add_op(OP_DUP,  8'd0, 32'd0);
        // Capacity above the stack size clamps; filter that empties the stack
        add_cfg(7'd127);
        add_op(OP_PUSH,   LEGS_DROP, 32'hDEAD_0002);
        add_op(OP_FILTER, 8'd0, 32'd0);
        add_op(OP_FILTER, 8'd0, 32'd0);

        // Random phases; the last runs without idling
        phases[0] = '{7'd64,  150, 60, 1'b1, 1'b0};
        phases[1] = '{7'd127,  80, 75, 1'b1, 1'b0};
        phases[2] = '{7'd10,  100, 40, 1'b1, 1'b1};
        phases[3] = '{7'd1,    60, 45, 1'b1, 1'b0};
        phases[4] = '{7'd0,    30, 50, 1'b1, 1'b0};
        phases[5] = '{7'd33,  120, 50, 1'b1, 1'b0};
        phases[6] = '{7'd64,  110, 55, 1'b0, 1'b0};

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG) write_capacity(row.cap);
            else send_op(row.op, row.legs, row.tag, row.typed, row.rep);
        end

        foreach (phases[p]) begin
            ph = phases[p];
            write_capacity(ph.cap);
            idle_on = ph.idle;
            // Request the long stall; the sender keeps offering meanwhile
            if (ph.hold) hold_req = 1'b1;
            repeat (ph.n_ops) begin
                rop = pick_op(ph.push_pct);
                send_op(rop, pick_legs(), $urandom, 1'b0, '0);
            end
        end

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
